FILE: hw/rtl/prr_pkg.sv
// shared constants, codes and helper functions for the point rotate and project block
package prr_pkg;

    // default sizes of the angle field and of the sine/cosine table
    localparam int ANGLE_BITS_DEF       = 16;
    localparam int TRIG_TABLE_DEPTH_DEF = 1024;

    // half pi in Q30 radians, used when the table is built
    localparam longint unsigned HALFPI_Q30 = 64'd1686629713;

    // fixed-point constants of the isometric projection (Q1.14)
    localparam int ISO_COS_Q14 = 14189;
    localparam int FRAC_BITS   = 14;

    // coordinate and product widths inside the datapath
    localparam int COORD_W = 32;
    localparam int PROD_W  = 49;

    // configuration register indexes
    localparam logic [2:0] REG_ZOOM         = 3'd0;
    localparam logic [2:0] REG_HEIGHT_SCALE = 3'd1;
    localparam logic [2:0] REG_CENTRE_X     = 3'd2;
    localparam logic [2:0] REG_CENTRE_Y     = 3'd3;
    localparam logic [2:0] REG_ANGLES       = 3'd4;
    localparam logic [2:0] REG_PROJ_MODE    = 3'd5;
    localparam logic [2:0] REG_SCREEN_OFF_X = 3'd6;
    localparam logic [2:0] REG_SCREEN_OFF_Y = 3'd7;

    // projection modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ISO   = 2'd1;
    localparam logic [1:0] MODE_SIDE  = 2'd2;

    // divide by 2^14 truncating toward zero
    function automatic logic signed [COORD_W-1:0] trunc_q14(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] adj;
        logic signed [PROD_W-1:0] shf;
        adj = v[PROD_W-1] ? (v + PROD_W'((1 << FRAC_BITS) - 1)) : v;
        shf = adj >>> FRAC_BITS;
        return shf[COORD_W-1:0];
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v > 34'sh0_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/prr_trig.sv
// sine and cosine lookup of one angle from a constant table, registered output
module prr_trig
    import prr_pkg::*;
#(
    parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
    parameter int TRIG_TABLE_DEPTH = TRIG_TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic [15:0]        i_angle,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos
);

    localparam int IDX_W = $clog2(TRIG_TABLE_DEPTH);
    localparam int MUL_W = ANGLE_BITS + IDX_W + 1;
    localparam longint unsigned DepthL = longint'(TRIG_TABLE_DEPTH);

    logic signed [15:0]     w_sin_tab [TRIG_TABLE_DEPTH];
    logic signed [15:0]     w_cos_tab [TRIG_TABLE_DEPTH];
    logic [ANGLE_BITS-1:0]  w_ang;
    logic [MUL_W-1:0]       w_prod;
    logic [IDX_W-1:0]       w_idx;
    logic signed [15:0]     r_sin;
    logic signed [15:0]     r_cos;

    // table built at elaboration: folded quarter-wave taylor series in q30
    for (genvar k = 0; k < TRIG_TABLE_DEPTH; k++) begin : g_tab
        for (genvar j = 0; j < 2; j++) begin : g_kind
            localparam longint unsigned P  = 4 * longint'(k) + longint'(j) * DepthL;
            localparam longint unsigned Q  = (P / DepthL) % 4;
            localparam longint unsigned R0 = P % DepthL;
            localparam longint unsigned R  = (Q % 2 == 1) ? (DepthL - R0) : R0;
            localparam longint unsigned XQ = (R * HALFPI_Q30) / DepthL;
            localparam longint unsigned X2 = (XQ * XQ) >> 30;
            localparam longint unsigned T1 = ((XQ * X2) >> 30) / 6;
            localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
            localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
            localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
            localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
            localparam longint S0 = longint'(XQ) - longint'(T1) + longint'(T2)
                                  - longint'(T3) + longint'(T4) - longint'(T5);
            localparam longint S  = (S0 < 0) ? 0 : S0;
            localparam longint M0 = (S + 32768) >>> 16;
            localparam longint M  = (M0 > 16384) ? 16384 : M0;
            localparam longint V  = (Q >= 2) ? -M : M;
            if (j == 0) begin : g_sin
                assign w_sin_tab[k] = 16'(V);
            end else begin : g_cos
                assign w_cos_tab[k] = 16'(V);
            end
        end
    end

    // table index = angle * depth >> angle bits
    assign w_ang  = i_angle[15 -: ANGLE_BITS];
    assign w_prod = MUL_W'(w_ang) * MUL_W'(TRIG_TABLE_DEPTH);
    assign w_idx  = w_prod[ANGLE_BITS +: IDX_W];

    // registered table read
    always_ff @(posedge i_clk) begin
        r_sin <= w_sin_tab[w_idx];
        r_cos <= w_cos_tab[w_idx];
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

FILE: hw/rtl/prr_rotate.sv
// two-stage plane rotation: o_a = trunc(a*c + b*s), o_b = trunc(b*c - a*s)
module prr_rotate
    import prr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [COORD_W-1:0] i_a,
    input  logic signed [COORD_W-1:0] i_b,
    input  logic signed [15:0]        i_c,
    input  logic signed [15:0]        i_s,
    output logic signed [COORD_W-1:0] o_a,
    output logic signed [COORD_W-1:0] o_b
);

    localparam int MW = COORD_W + 16;

    logic signed [MW-1:0]      r_ac;
    logic signed [MW-1:0]      r_bs;
    logic signed [MW-1:0]      r_bc;
    logic signed [MW-1:0]      r_as;
    logic signed [PROD_W-1:0]  w_sum_a;
    logic signed [PROD_W-1:0]  w_sum_b;
    logic signed [COORD_W-1:0] r_a;
    logic signed [COORD_W-1:0] r_b;

    // stage one: four products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ac <= i_a * i_c;
            r_bs <= i_b * i_s;
            r_bc <= i_b * i_c;
            r_as <= i_a * i_s;
        end
    end

    // stage two: combine and truncate toward zero
    assign w_sum_a = PROD_W'(r_ac) + PROD_W'(r_bs);
    assign w_sum_b = PROD_W'(r_bc) - PROD_W'(r_as);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= trunc_q14(w_sum_a);
            r_b <= trunc_q14(w_sum_b);
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;

endmodule

FILE: hw/rtl/point_rotate_project.sv
// top level: vertex scale, three euler rotations, projection and screen offset
//
// Input stream (s_axis): one map vertex per transfer, packed in tdata.
// Output stream (m_axis): one screen point per input vertex, in order.
// Configuration channel: index 0..7 selects zoom, height scale, centre x/y,
// packed rotation angles, projection mode, screen offset x/y; cfg_ready is
// always high and a write is registered; angle writes also pass through the
// registered sine/cosine lookup. Write it only while no vertex is in flight.
// The pipeline has ten stages, the first loaded at the input transfer, then
// the output register. Throughput: one vertex per cycle while the output is
// not stalled; the three rotation units and the isometric multiplier are
// each fully pipelined, and the sine/cosine tables are read every cycle
// from the angle registers.
// A stalled receiver first fills a one-entry skid register behind the
// output register; then the whole pipeline holds and s_axis_tready drops
// until the output drains. Nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and restores zoom 1,
// height scale 1, isometric mode and zero centres, angles and offsets.
module point_rotate_project
    import prr_pkg::*;
#(
    parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
    parameter int TRIG_TABLE_DEPTH = TRIG_TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input vertex stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // map_x[9:0], map_y[19:10], height[35:20], zero pad
    // output point stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [95:0] o_m_axis_tdata,   // screen_x[31:0], screen_y[63:32], depth[95:64]
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    localparam int NSTG = 10;

    // configuration registers
    logic [7:0]         r_zoom;
    logic [7:0]         r_hscale;
    logic [19:0]        r_cx;
    logic [19:0]        r_cy;
    logic [47:0]        r_angles;
    logic [1:0]         r_mode;
    logic signed [16:0] r_offx;
    logic signed [16:0] r_offy;

    // pipeline control
    logic [NSTG:1]      r_v;
    logic               w_en;
    logic               w_take;

    // trig values
    logic signed [15:0] w_sx, w_cx_t, w_sy, w_cy_t, w_sz, w_cz_t;

    // input fields
    logic [9:0]          w_map_x;
    logic [9:0]          w_map_y;
    logic signed [15:0]  w_height;

    // datapath registers
    logic signed [COORD_W-1:0] r1_x, r1_y, r1_z;
    logic signed [COORD_W-1:0] r2_x, r3_x;
    logic signed [COORD_W-1:0] w_rx_y, w_rx_z;
    logic signed [COORD_W-1:0] r4_y, r5_y;
    logic signed [COORD_W-1:0] w_ry_x, w_ry_z;
    logic signed [COORD_W-1:0] r6_z, r7_z;
    logic signed [COORD_W-1:0] w_rz_y, w_rz_x;
    logic signed [PROD_W-1:0]  r8_d, r8_e;
    logic signed [COORD_W-1:0] r8_x, r8_y, r8_z;
    logic [1:0]                r8_mode;
    logic signed [32:0]        r9_x, r9_y, r9_z;
    logic signed [31:0]        r10_x, r10_y, r10_z;
    logic signed [32:0]        w_dif, w_sum;
    logic [17:0]               w_prod_x;
    logic [17:0]               w_prod_y;
    logic signed [24:0]        w_prod_z;
    logic signed [PROD_W-1:0]  w_iso_d;

    // output register and skid
    logic [95:0] r_out, r_skid;
    logic        r_ov, r_sv;

    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom   <= 8'd1;
            r_hscale <= 8'd1;
            r_cx     <= '0;
            r_cy     <= '0;
            r_angles <= '0;
            r_mode   <= MODE_ISO;
            r_offx   <= '0;
            r_offy   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ZOOM:         r_zoom   <= i_cfg_data[7:0];
                REG_HEIGHT_SCALE: r_hscale <= i_cfg_data[7:0];
                REG_CENTRE_X:     r_cx     <= i_cfg_data[19:0];
                REG_CENTRE_Y:     r_cy     <= i_cfg_data[19:0];
                REG_ANGLES:       r_angles <= i_cfg_data;
                REG_PROJ_MODE:    r_mode   <= i_cfg_data[1:0];
                REG_SCREEN_OFF_X: r_offx   <= i_cfg_data[16:0];
                REG_SCREEN_OFF_Y: r_offy   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // sine and cosine of each angle, one lookup per axis
    prr_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_trig_x (
        .i_clk(i_clk), .i_angle(r_angles[15:0]), .o_sin(w_sx), .o_cos(w_cx_t));
    prr_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_trig_y (
        .i_clk(i_clk), .i_angle(r_angles[31:16]), .o_sin(w_sy), .o_cos(w_cy_t));
    prr_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_trig_z (
        .i_clk(i_clk), .i_angle(r_angles[47:32]), .o_sin(w_sz), .o_cos(w_cz_t));

    // pipeline advances unless the skid holds a point
    assign w_en            = !r_sv;
    assign o_s_axis_tready = w_en;
    assign w_take          = w_en && r_v[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NSTG-1:1], i_s_axis_tvalid};
        end
    end

    // stage 1: scale and centre
    assign w_map_x  = i_s_axis_tdata[9:0];
    assign w_map_y  = i_s_axis_tdata[19:10];
    assign w_height = i_s_axis_tdata[35:20];

    // full-width scale products
    assign w_prod_x = 18'(w_map_x) * 18'(r_zoom);
    assign w_prod_y = 18'(w_map_y) * 18'(r_zoom);
    assign w_prod_z = 25'(w_height) * 25'($signed({1'b0, r_hscale}));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x <= $signed(COORD_W'(w_prod_x)) - $signed(COORD_W'(r_cx));
            r1_y <= $signed(COORD_W'(w_prod_y)) - $signed(COORD_W'(r_cy));
            r1_z <= COORD_W'(w_prod_z);
        end
    end

    // stages 2-3: rotation about x (y, z)
    prr_rotate u_rot_x (
        .i_clk(i_clk), .i_en(w_en), .i_a(r1_y), .i_b(r1_z), .i_c(w_cx_t), .i_s(w_sx),
        .o_a(w_rx_y), .o_b(w_rx_z));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_x <= r1_x;
            r3_x <= r2_x;
        end
    end

    // stages 4-5: rotation about y (x, z)
    prr_rotate u_rot_y (
        .i_clk(i_clk), .i_en(w_en), .i_a(r3_x), .i_b(w_rx_z), .i_c(w_cy_t), .i_s(w_sy),
        .o_a(w_ry_x), .o_b(w_ry_z));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_y <= w_rx_y;
            r5_y <= r4_y;
        end
    end

    // stages 6-7: rotation about z, with a = y and b = x
    prr_rotate u_rot_z (
        .i_clk(i_clk), .i_en(w_en), .i_a(r5_y), .i_b(w_ry_x), .i_c(w_cz_t), .i_s(w_sz),
        .o_a(w_rz_y), .o_b(w_rz_x));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_z <= w_ry_z;
            r7_z <= r6_z;
        end
    end

    // stage 8: isometric products
    assign w_dif   = 33'(w_rz_x) - 33'(w_rz_y);
    assign w_sum   = 33'(w_rz_x) + 33'(w_rz_y);
    assign w_iso_d = PROD_W'(w_dif) * PROD_W'($signed(16'(ISO_COS_Q14)));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_d    <= w_iso_d;
            r8_e    <= (PROD_W'(w_sum) <<< (FRAC_BITS - 1)) - (PROD_W'(r7_z) <<< FRAC_BITS);
            r8_x    <= w_rz_x;
            r8_y    <= w_rz_y;
            r8_z    <= r7_z;
            r8_mode <= r_mode;
        end
    end

    // stage 9: projection select
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            case (r8_mode)
                MODE_ISO: begin
                    r9_x <= 33'(trunc_q14(r8_d));
                    r9_y <= 33'(trunc_q14(r8_e));
                    r9_z <= 33'(r8_z);
                end
                MODE_SIDE: begin
                    r9_x <= 33'(r8_x);
                    r9_y <= -33'(r8_z);
                    r9_z <= 33'(r8_y);
                end
                default: begin
                    r9_x <= 33'(r8_x);
                    r9_y <= 33'(r8_y);
                    r9_z <= 33'(r8_z);
                end
            endcase
        end
    end

    // stage 10: screen offsets and saturation
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_x <= sat32(34'(r9_x) + 34'(r_offx));
            r10_y <= sat32(34'(r9_y) + 34'(r_offy));
            r10_z <= sat32(34'(r9_z));
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || i_m_axis_tready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= w_take;
            end
        end else if (w_take) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_m_axis_tready) begin
            if (r_sv) begin
                r_out <= r_skid;
            end else if (w_take) begin
                r_out <= {r10_z, r10_y, r10_x};
            end
        end else if (w_take) begin
            r_skid <= {r10_z, r10_y, r10_x};
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_out;

endmodule
